// ===== rtl/pffc_pkg.sv =====
// Shared types and constants of the PCM frame format converter.
// No dependencies; imported by pffc_front, pffc_back and the top level.
package pffc_pkg;

  localparam int WORD_W    = 32;
  localparam int FQ_IDX_W  = 4;
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_CNT_W = 3;

  typedef enum logic [1:0] {
    SRC_PCM16 = 2'd0,
    SRC_PCM24 = 2'd1,
    SRC_PCM32 = 2'd2,
    SRC_FLOAT = 2'd3
  } src_fmt_t;

  typedef enum logic [1:0] {
    DST_PCM16 = 2'd0,
    DST_PCM32 = 2'd1,
    DST_FLOAT = 2'd2,
    DST_NONE  = 2'd3
  } dst_fmt_t;

  typedef enum logic [2:0] {
    REG_SRC_FMT = 3'd0,
    REG_SRC_CH  = 3'd1,
    REG_DST_FMT = 3'd2,
    REG_DST_CH  = 3'd3,
    REG_REPEAT  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0] src_fmt;
    logic [5:0] src_n;
    logic [1:0] dst_fmt;
    logic [4:0] dst_n;
    logic [5:0] keep_n;
    logic [4:0] reps_n;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0]   word;
    logic [FQ_IDX_W-1:0] idx;
    logic                wr;
    logic                last;
  } fq_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [2:0]        chan;
    logic [2:0]        rep;
    logic              last;
  } res_t;

endpackage

// ===== rtl/pffc_queue.sv =====
// Small register queue used between front and back and on the result side.
// Depends on nothing; width and depth come from parameters.
module pffc_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [W-1:0]               wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [W-1:0]               rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] cnt
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign cnt     = cnt_r;
  assign rdata   = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + AW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

// ===== rtl/pffc_front.sv =====
// Front end: accepts source samples, tracks the frame position and decodes to float.
// Depends on pffc_pkg.
module pffc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  pffc_pkg::cfg_t     cfg,
  input  logic               in_push,
  input  logic [31:0]        in_sample_word,
  output logic               in_full,
  output pffc_pkg::fq_t      q_data,
  output logic               q_push,
  input  logic               q_full
);
  import pffc_pkg::*;

  logic [4:0]  pos_r, pos_nxt;
  logic        accept, adv2, take1;

  logic        s1_v_r, s1_neg_r, s1_zero_r, s1_flt_r, s1_s16_r, s1_wr_r, s1_last_r;
  logic [31:0] s1_mag_r, s1_word_r;
  logic [4:0]  s1_msb_r;
  logic [3:0]  s1_idx_r;

  logic        s2_v_r;
  fq_t         s2_r;

  logic [31:0] sw, mag, shl, kp, mask;
  logic        neg, rnd, guard, sticky, wr_c, last_c;
  logic [4:0]  msb;
  logic [3:0]  sh;
  logic [7:0]  exp8;
  logic [22:0] mant;
  logic [30:0] body;
  logic [31:0] fbits;

  assign adv2    = !s2_v_r || !q_full;
  assign take1   = !s1_v_r || adv2;
  assign in_full = !take1;
  assign accept  = in_push && take1;
  assign q_push  = s2_v_r;
  assign q_data  = s2_r;

  always_comb begin
    case (cfg.src_fmt)
      SRC_PCM16: sw = {{16{in_sample_word[15]}}, in_sample_word[15:0]};
      SRC_PCM24: sw = {in_sample_word[23:16], in_sample_word[15:8],
                       in_sample_word[7:0], in_sample_word[23:16]};
      default:   sw = in_sample_word;
    endcase
    neg = sw[31];
    mag = neg ? (32'd0 - sw) : sw;
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) begin
        msb = 5'(i);
      end
    end
    wr_c   = ({1'b0, pos_r} < cfg.keep_n);
    last_c = ({1'b0, pos_r} + 6'd1 >= cfg.src_n);
    pos_nxt = last_c ? '0 : pos_r + 5'd1;
  end

  always_comb begin
    exp8   = (s1_s16_r ? 8'd112 : 8'd96) + {3'b0, s1_msb_r};
    sh     = '0;
    kp     = '0;
    mask   = '0;
    guard  = 1'b0;
    sticky = 1'b0;
    rnd    = 1'b0;
    shl    = '0;
    if (s1_msb_r <= 5'd23) begin
      shl  = s1_mag_r << (5'd23 - s1_msb_r);
      mant = shl[22:0];
    end else begin
      sh     = 4'(s1_msb_r - 5'd23);
      kp     = s1_mag_r >> sh;
      guard  = s1_mag_r[5'(sh - 4'd1)];
      mask   = (32'd1 << (sh - 4'd1)) - 32'd1;
      sticky = |(s1_mag_r & mask);
      rnd    = guard && (sticky || kp[0]);
      mant   = kp[22:0];
    end
    body  = {exp8, mant} + {30'd0, rnd};
    fbits = s1_zero_r ? 32'd0 : {s1_neg_r, body};
    if (s1_flt_r) begin
      fbits = s1_word_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (accept) begin
        pos_r <= pos_nxt;
      end
      if (take1) begin
        s1_v_r <= accept;
      end
      if (adv2) begin
        s2_v_r <= s1_v_r && (s1_wr_r || s1_last_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take1) begin
      s1_neg_r  <= neg;
      s1_zero_r <= (mag == 32'd0);
      s1_flt_r  <= (cfg.src_fmt == SRC_FLOAT);
      s1_s16_r  <= (cfg.src_fmt == SRC_PCM16);
      s1_mag_r  <= mag;
      s1_msb_r  <= msb;
      s1_word_r <= in_sample_word;
      s1_idx_r  <= pos_r[3:0];
      s1_wr_r   <= wr_c;
      s1_last_r <= last_c;
    end
    if (adv2) begin
      s2_r.word <= fbits;
      s2_r.idx  <= s1_idx_r;
      s2_r.wr   <= s1_wr_r;
      s2_r.last <= s1_last_r;
    end
  end

endmodule

// ===== rtl/pffc_back.sv =====
// Back end: holds the decoded frame and emits it, encoded, repeat times over.
// Depends on pffc_pkg.
module pffc_back #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_REPEAT   = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pffc_pkg::cfg_t               cfg,
  input  pffc_pkg::fq_t                q_data,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  logic [pffc_pkg::OUT_CNT_W-1:0] o_cnt,
  output pffc_pkg::res_t               o_data,
  output logic                         o_push
);
  import pffc_pkg::*;

  localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CW = $clog2(MAX_CHANNELS + 1);
  localparam int RW = $clog2(MAX_REPEAT + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } st_t;

  st_t          st_r, st_nxt;
  logic [31:0]  store_r [MAX_CHANNELS];
  logic [CW-1:0] c_r, c_nxt;
  logic [RW-1:0] r_r, r_nxt;
  logic [4:0]   c5, r5;
  logic         issue, c_end, r_end;
  logic [31:0]  val;

  logic         a_v_r;
  logic [31:0]  a_bits_r;
  logic [38:0]  a_prod_r;
  logic [2:0]   a_chan_r, a_rep_r;
  logic         a_last_r;

  logic        sgn, big, nan, hi, g16, s16;
  logic [7:0]  ex;
  logic [22:0] mt;
  logic [23:0] top, m24;
  logic [24:0] kk;
  logic [9:0]  tt;
  logic [9:0]  rs;
  logic [31:0] mag32, res32;
  logic [24:0] mag16;
  logic [15:0] res16;

  assign c5    = 5'(c_r);
  assign r5    = 5'(r_r);
  assign c_end = (c5 + 5'd1 == cfg.dst_n);
  assign r_end = (r5 + 5'd1 == cfg.reps_n);
  assign issue = (st_r == ST_EMIT) &&
                 ({1'b0, o_cnt} + {3'b0, a_v_r} < 4'(OUT_DEPTH));
  assign q_pop = (st_r == ST_IDLE) && !q_empty;
  assign val   = ({1'b0, c5} < cfg.keep_n) ? store_r[c_r[IW-1:0]] : 32'd0;

  always_comb begin
    st_nxt = st_r;
    c_nxt  = c_r;
    r_nxt  = r_r;
    case (st_r)
      ST_IDLE: begin
        if (q_pop && q_data.last) begin
          st_nxt = ST_EMIT;
          c_nxt  = '0;
          r_nxt  = '0;
        end
      end
      ST_EMIT: begin
        if (issue) begin
          if (c_end) begin
            c_nxt = '0;
            r_nxt = r_r + RW'(1);
            if (r_end) begin
              st_nxt = ST_IDLE;
            end
          end else begin
            c_nxt = c_r + CW'(1);
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      c_r   <= '0;
      r_r   <= '0;
      a_v_r <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      st_r  <= st_nxt;
      c_r   <= c_nxt;
      r_r   <= r_nxt;
      a_v_r <= issue;
      if (q_pop && q_data.wr) begin
        store_r[q_data.idx[IW-1:0]] <= q_data.word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      a_bits_r <= val;
      a_prod_r <= 39'({1'b1, val[22:0]}) * 39'd32767;
      a_chan_r <= c5[2:0];
      a_rep_r  <= r5[2:0];
      a_last_r <= c_end && r_end;
    end
  end

  always_comb begin
    sgn = a_bits_r[31];
    ex  = a_bits_r[30:23];
    mt  = a_bits_r[22:0];
    nan = (ex == 8'hFF) && (mt != '0);
    m24 = {1'b1, mt};

    mag32 = '0;
    if (ex >= 8'd119) begin
      mag32 = 32'(m24) << (ex - 8'd119);
    end else begin
      mag32 = 32'(m24) >> (8'd119 - ex);
    end
    if (nan || ex < 8'd96) begin
      res32 = '0;
    end else if (ex >= 8'd127) begin
      res32 = sgn ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      res32 = sgn ? (32'd0 - mag32) : mag32;
    end

    hi   = a_prod_r[38];
    top  = hi ? a_prod_r[38:15] : a_prod_r[37:14];
    g16  = hi ? a_prod_r[14] : a_prod_r[13];
    s16  = hi ? |a_prod_r[13:0] : |a_prod_r[12:0];
    kk   = {1'b0, top} + {24'd0, g16 && (s16 || top[0])};
    tt   = {2'b0, ex} - (hi ? 10'd135 : 10'd136);
    rs   = 10'd0 - tt;
    big  = (ex == 8'hFF) || !tt[9];
    mag16 = (rs >= 10'd25) ? 25'd0 : (kk >> rs[4:0]);
    if (nan || ex == 8'd0) begin
      res16 = '0;
    end else if (sgn) begin
      res16 = (big || mag16 >= 25'd32768) ? 16'h8000 : (16'd0 - mag16[15:0]);
    end else begin
      res16 = (big || mag16 >= 25'd32767) ? 16'h7FFF : mag16[15:0];
    end

    case (cfg.dst_fmt)
      DST_PCM16: o_data.word = {16'd0, res16};
      DST_PCM32: o_data.word = res32;
      DST_FLOAT: o_data.word = a_bits_r;
      default:   o_data.word = '0;
    endcase
    o_data.chan = a_chan_r;
    o_data.rep  = a_rep_r;
    o_data.last = a_last_r;
  end

  assign o_push = a_v_r;

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    a_v_r |-> (o_cnt < OUT_CNT_W'(OUT_DEPTH)))
    else $error("result queue overrun");
  a_no_pop_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EMIT) |-> !q_pop)
    else $error("front queue popped during emission");
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && c_end && r_end) |=> (st_r == ST_IDLE))
    else $error("emission did not finish after last sample");
  a_last_chan: assert property (@(posedge clk) disable iff (!rst_n)
    (a_v_r && a_last_r) |-> (a_chan_r == 3'(cfg.dst_n - 5'd1)))
    else $error("last_of_run on wrong channel");
`endif

endmodule

// ===== rtl/pcm_frame_format_converter.sv =====
// Top level of the PCM frame format converter: config registers, front, queues, back.
// Depends on pffc_pkg, pffc_queue, pffc_front and pffc_back.
//
//  channel | handshake          | payload
//  in      | in_push / in_full  | in_sample_word
//  out     | out_pop / out_empty| out_word, out_channel, out_repeat, out_last_of_run
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A sample passes the two-stage decoder; one sample a cycle enters while the decoder is not stalled.
// A frame end emits dest_channels x repeat_count results at one a cycle from the back
// end's encode stage, bounded by result pops; the front keeps taking samples meanwhile
// and stalls once the two-entry middle queue and both decoder stages hold requests.
// Reset is synchronous and clears the frame store.
module pcm_frame_format_converter #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_REPEAT   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_sample_word,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_word,
  output logic [2:0]  out_channel,
  output logic [2:0]  out_repeat,
  output logic        out_last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import pffc_pkg::*;

  logic [1:0] src_fmt_r, dst_fmt_r;
  logic [5:0] src_ch_r;
  logic [3:0] dst_ch_r, rep_r;
  logic       cfg_wr;
  cfg_t       cfg;

  fq_t        mid_wdata, mid_rdata;
  logic       mid_push, mid_full, mid_pop, mid_empty;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_cnt;

  res_t       res_wdata, res_rdata;
  logic       res_push, res_full;
  logic [OUT_CNT_W-1:0] res_cnt;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_fmt_r <= 2'd0;
      src_ch_r  <= 6'd2;
      dst_fmt_r <= 2'd0;
      dst_ch_r  <= 4'd2;
      rep_r     <= 4'd1;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_SRC_FMT: src_fmt_r <= cfg_data[1:0];
        REG_SRC_CH:  src_ch_r  <= cfg_data[5:0];
        REG_DST_FMT: dst_fmt_r <= cfg_data[1:0];
        REG_DST_CH:  dst_ch_r  <= cfg_data[3:0];
        REG_REPEAT:  rep_r     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.src_fmt = src_fmt_r;
    cfg.dst_fmt = dst_fmt_r;
    if (src_ch_r == 6'd0) begin
      cfg.src_n = 6'd1;
    end else if (src_ch_r > 6'd32) begin
      cfg.src_n = 6'd32;
    end else begin
      cfg.src_n = src_ch_r;
    end
    if (dst_ch_r == 4'd0) begin
      cfg.dst_n = 5'd1;
    end else if ({1'b0, dst_ch_r} > 5'(MAX_CHANNELS)) begin
      cfg.dst_n = 5'(MAX_CHANNELS);
    end else begin
      cfg.dst_n = {1'b0, dst_ch_r};
    end
    if (rep_r == 4'd0) begin
      cfg.reps_n = 5'd1;
    end else if ({1'b0, rep_r} > 5'(MAX_REPEAT)) begin
      cfg.reps_n = 5'(MAX_REPEAT);
    end else begin
      cfg.reps_n = {1'b0, rep_r};
    end
    cfg.keep_n = (cfg.src_n < {1'b0, cfg.dst_n}) ? cfg.src_n : {1'b0, cfg.dst_n};
  end

  pffc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_push        (in_push),
    .in_sample_word (in_sample_word),
    .in_full        (in_full),
    .q_data         (mid_wdata),
    .q_push         (mid_push),
    .q_full         (mid_full)
  );

  pffc_queue #(.W($bits(fq_t)), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty),
    .cnt   (mid_cnt)
  );

  pffc_back #(.MAX_CHANNELS(MAX_CHANNELS), .MAX_REPEAT(MAX_REPEAT)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_data  (mid_rdata),
    .q_empty (mid_empty),
    .q_pop   (mid_pop),
    .o_cnt   (res_cnt),
    .o_data  (res_wdata),
    .o_push  (res_push)
  );

  pffc_queue #(.W($bits(res_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty),
    .cnt   (res_cnt)
  );

  assign out_word        = res_rdata.word;
  assign out_channel     = res_rdata.chan;
  assign out_repeat      = res_rdata.rep;
  assign out_last_of_run = res_rdata.last;

`ifndef SYNTHESIS
  a_res_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");
  a_mid_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mid_cnt <= ($clog2(MID_DEPTH+1))'(MID_DEPTH))
    else $error("middle queue count out of range");
  a_mid_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (mid_push && mid_full) |=> $stable(mid_wdata))
    else $error("front changed a stalled entry");
`endif

endmodule

// ===== test/pffc_checker.sv =====
// Checker for the PCM frame format converter: follows the three channels,
// predicts every result from the accepted requests and compares in order.
// Depends on pffc_pkg for the format, register and result types.
module pffc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [31:0] in_sample_word,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [31:0] out_word,
  input  logic [2:0]  out_channel,
  input  logic [2:0]  out_repeat,
  input  logic        out_last_of_run,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import pffc_pkg::*;

  logic [1:0]  src_fmt;
  logic [5:0]  src_n;
  logic [1:0]  dst_fmt;
  logic [3:0]  dst_n;
  logic [3:0]  rep_n;
  logic [4:0]  frame_pos;
  logic [31:0] frame_vals [8];
  res_t        sample_q [$];

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic real single_to_real(logic [31:0] b);
    logic [7:0]  e;
    real         r;
    e = b[30:23];
    if (e == 8'd255)
      r = $bitstoreal(64'h7FF0_0000_0000_0000);
    else if (e == 8'd0)
      r = real'(b[22:0]) * (2.0 ** (-149));
    else
      r = $bitstoreal({1'b0, 11'(e) + 11'd896, b[22:0], 29'b0});
    return b[31] ? -r : r;
  endfunction

  function automatic real round_single(real x);
    logic [63:0] d;
    logic [28:0] low;
    logic        up;
    d = $realtobits(x);
    if (x == 0.0 || d[62:52] == 11'h7FF) return x;
    low = d[28:0];
    up = (low > 29'h1000_0000) || (low == 29'h1000_0000 && d[29]);
    return $bitstoreal({d[63], d[62:29] + 34'(up), 29'b0});
  endfunction

  function automatic logic [31:0] decode_sample(logic [31:0] w);
    logic [31:0] v, mag, keep, rem, half;
    logic [63:0] d;
    logic        neg;
    int          sh;
    real         scl, f;
    case (src_fmt)
      SRC_PCM16: begin
        v = {{16{w[15]}}, w[15:0]};
        scl = 1.0 / 32768.0;
      end
      SRC_PCM24: begin
        v = {w[23:16], w[15:8], w[7:0], w[23:16]};
        scl = 1.0 / 2147483648.0;
      end
      SRC_PCM32: begin
        v = w;
        scl = 1.0 / 2147483648.0;
      end
      default: return w;
    endcase
    neg = v[31];
    mag = neg ? (32'd0 - v) : v;
    sh = 0;
    while ((mag >> sh) >= 32'h0100_0000) sh++;
    keep = mag >> sh;
    if (sh > 0) begin
      rem = mag & ((32'd1 << sh) - 32'd1);
      half = 32'd1 << (sh - 1);
      if (rem > half || (rem == half && keep[0])) keep++;
    end
    f = real'(keep) * (2.0 ** sh) * scl;
    if (f == 0.0) return 32'd0;
    d = $realtobits(f);
    return {neg, 8'(d[62:52] - 11'd896), d[51:29]};
  endfunction

  function automatic logic [31:0] encode_value(logic [31:0] b);
    logic is_nan;
    real  v, p;
    int   s;
    is_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    v = single_to_real(b);
    case (dst_fmt)
      DST_PCM16: begin
        if (is_nan) return 32'd0;
        p = round_single(v * 32767.0);
        if (p >= 32767.0) s = 32767;
        else if (p <= -32768.0) s = -32768;
        else s = $rtoi(p);
        return {16'd0, s[15:0]};
      end
      DST_PCM32: begin
        if (is_nan) return 32'd0;
        p = v * 2147483648.0;
        if (p >= 2147483648.0) s = 32'h7FFF_FFFF;
        else if (p <= -2147483648.0) s = 32'h8000_0000;
        else s = $rtoi(p);
        return 32'(s);
      end
      DST_FLOAT: return b;
      default:   return 32'd0;
    endcase
  endfunction

  task automatic convert_sample(logic [31:0] w);
    int   src, dst, reps, keep, pos;
    res_t r;
    src  = (src_n < 1) ? 1 : (src_n > 32 ? 32 : int'(src_n));
    dst  = (dst_n < 1) ? 1 : (dst_n > 8 ? 8 : int'(dst_n));
    reps = (rep_n < 1) ? 1 : (rep_n > 8 ? 8 : int'(rep_n));
    keep = (src < dst) ? src : dst;
    pos  = int'(frame_pos);
    if (pos < keep) frame_vals[pos] = decode_sample(w);
    if (pos + 1 < src) begin
      frame_pos = 5'(pos + 1);
      return;
    end
    frame_pos = 5'd0;
    for (int rp = 0; rp < reps; rp++) begin
      for (int c = 0; c < dst; c++) begin
        r.word = encode_value(c < keep ? frame_vals[c] : 32'd0);
        r.chan = 3'(c);
        r.rep  = 3'(rp);
        r.last = (rp + 1 == reps) && (c + 1 == dst);
        sample_q.push_back(r);
      end
    end
  endtask

  initial begin
    fail_count = 0;
    results_seen = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    res_t w;
    if (!rst_n) begin
      src_fmt = SRC_PCM16;
      src_n = 6'd2;
      dst_fmt = DST_PCM16;
      dst_n = 4'd2;
      rep_n = 4'd1;
      frame_pos = 5'd0;
      for (int i = 0; i < 8; i++) frame_vals[i] = 32'd0;
      sample_q.delete();
    end else begin
      if (out_pop && !out_empty) begin
        results_seen++;
        if (sample_q.size() == 0) begin
          report_mismatch("unexpected result", out_word, 32'd0);
        end else begin
          w = sample_q.pop_front();
          if (out_word !== w.word) report_mismatch("out_word", out_word, w.word);
          if (out_channel !== w.chan) report_mismatch("out_channel", 32'(out_channel), 32'(w.chan));
          if (out_repeat !== w.rep) report_mismatch("out_repeat", 32'(out_repeat), 32'(w.rep));
          if (out_last_of_run !== w.last)
            report_mismatch("out_last_of_run", 32'(out_last_of_run), 32'(w.last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SRC_FMT: src_fmt = cfg_data[1:0];
          REG_SRC_CH:  src_n = cfg_data[5:0];
          REG_DST_FMT: dst_fmt = cfg_data[1:0];
          REG_DST_CH:  dst_n = cfg_data[3:0];
          REG_REPEAT:  rep_n = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) convert_sample(in_sample_word);
    end
    pending = sample_q.size();
  end
endmodule

// ===== test/testbench.sv =====
// Top of the converter testbench: clock, reset, register writes and sample requests.
// Depends on pffc_pkg, pffc_checker and the pcm_frame_format_converter RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pffc_pkg::*;

  logic        clk, rst_n;
  logic        in_push, in_full;
  logic [31:0] in_sample_word;
  logic        out_empty, out_pop;
  logic [31:0] out_word;
  logic [2:0]  out_channel, out_repeat;
  logic        out_last_of_run;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;
  int          fail_count, pending, results_seen;
  int          n_samples, n_writes, stall_cycles;
  logic        no_idle;

  pcm_frame_format_converter u_top (.*);

  pffc_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) out_pop <= no_idle || ($urandom_range(99) >= 24);

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else if (stall_cycles >= 4000) begin
      $display("TB_ERROR");
      $finish;
    end else
      stall_cycles <= stall_cycles + 1;
  end

  task automatic drain_results();
    in_push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    drain_results();
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_writes++;
  endtask

  task automatic send_sample(logic [31:0] w);
    if (!no_idle && $urandom_range(99) < 24) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
    in_push <= 1'b1;
    in_sample_word <= w;
    do @(posedge clk); while (in_full);
    @(negedge clk);
    n_samples++;
  endtask

  initial begin
    logic [7:0] v;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_sample_word = '0;
    out_pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    no_idle = 1'b0;
    n_samples = 0;
    n_writes = 0;
    stall_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: pcm16 in and out, full-scale extremes
    send_sample(32'h0000_7FFF);
    send_sample(32'hFFFF_8000);
    write_reg(REG_SRC_FMT, SRC_PCM24);
    write_reg(REG_SRC_CH, 8'd3);
    write_reg(REG_DST_FMT, DST_PCM32);
    write_reg(REG_REPEAT, 8'd2);
    send_sample(32'h007F_FFFF);
    send_sample(32'hFF80_0000);
    send_sample(32'h0012_3456);
    // one source channel into eight, repeated eight times
    write_reg(REG_SRC_FMT, SRC_FLOAT);
    write_reg(REG_SRC_CH, 8'd1);
    write_reg(REG_DST_FMT, DST_FLOAT);
    write_reg(REG_DST_CH, 8'd8);
    write_reg(REG_REPEAT, 8'd8);
    send_sample(32'h7FC0_0001);
    write_reg(REG_SRC_CH, 8'd4);
    write_reg(REG_DST_CH, 8'd4);
    write_reg(REG_REPEAT, 8'd1);
    write_reg(REG_DST_FMT, DST_PCM16);
    send_sample(32'h7FC0_0000);
    send_sample(32'h7F80_0000);
    send_sample(32'hFF80_0000);
    send_sample(32'h3F80_0000);
    write_reg(REG_DST_FMT, DST_PCM32);
    send_sample(32'h0000_0001);
    send_sample(32'hBF80_0000);
    // mid-frame shrink of the source frame ends it on the next sample
    write_reg(REG_SRC_CH, 8'd1);
    send_sample(32'h3F00_0000);
    write_reg(REG_SRC_FMT, SRC_PCM32);
    write_reg(REG_DST_FMT, DST_NONE);
    write_reg(REG_SRC_CH, 8'd0);
    write_reg(REG_DST_CH, 8'd0);
    write_reg(REG_REPEAT, 8'd0);
    send_sample(32'h8000_0000);
    write_reg(REG_DST_FMT, DST_PCM32);
    write_reg(REG_SRC_CH, 8'd63);
    write_reg(REG_DST_CH, 8'd15);
    write_reg(REG_REPEAT, 8'd15);
    for (int i = 0; i < 32; i++) send_sample(i[0] ? 32'h7FFF_FFFF : 32'hFFFF_FFFF);

    for (int ph = 0; ph < 16; ph++) begin
      no_idle = (ph >= 6 && ph < 9);
      write_reg(REG_SRC_FMT, 8'($urandom) & 8'hFC | 8'($urandom_range(3)));
      v = ($urandom_range(9) == 0) ? 8'($urandom_range(63)) : 8'($urandom_range(1, 4));
      write_reg(REG_SRC_CH, 8'($urandom) & 8'hC0 | v);
      write_reg(REG_DST_FMT, 8'($urandom) & 8'hFC | 8'($urandom_range(3)));
      write_reg(REG_DST_CH, 8'($urandom) & 8'hF0 | 8'($urandom_range(15)));
      v = ($urandom_range(4) == 0) ? 8'($urandom_range(15)) : 8'($urandom_range(1, 3));
      write_reg(REG_REPEAT, 8'($urandom) & 8'hF0 | v);
      if ($urandom_range(3) == 0) write_reg(3'($urandom_range(5, 7)), 8'($urandom));
      repeat ($urandom_range(2, 8)) begin
        case ($urandom_range(7))
          0:       send_sample(32'd0);
          1:       send_sample(32'hFFFF_FFFF);
          2:       send_sample(32'h3F80_0000 ^ 32'($urandom_range(255)));
          3:       send_sample(32'hBF7F_FF00 | 32'($urandom_range(255)));
          4:       send_sample(32'h7F80_0000 | 32'($urandom_range(1)) | 32'($urandom) & 32'h8000_0000);
          5:       send_sample(32'($urandom) & 32'h807F_FFFF);
          default: send_sample($urandom);
        endcase
      end
    end
    no_idle = 1'b0;

    drain_results();
    $display("sent %0d samples with %0d register writes; %0d results checked",
             n_samples, n_writes, results_seen);
    $display("covered pcm16/24/32/float in, pcm16/32/float/none out, clamped registers");
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
